@@ rtl/core/etvad_pkg.sv @@
// Shared types and constants for the energy-threshold voice activity detector.
package etvad_pkg;

	// Configuration register widths and reset values.
	localparam int RATE_W     = 18;
	localparam int MILLIS_W   = 10;
	localparam int LIMIT_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int CFG_DATA_W = 18;

	localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd16000;
	localparam logic [MILLIS_W-1:0] MILLIS_RESET = 10'd30;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd500;
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd1;

	// Frame length is rate * millis / 1000; the divide is a reciprocal multiply
	// that is exact for every product below 2^PROD_W.
	localparam int PROD_W     = RATE_W + MILLIS_W;
	localparam int LEN_W      = 19;
	localparam int DIV_SHIFT  = 38;
	localparam int DIV_MULT_W = 29;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = 29'd274877907;

	// Threshold is energy_limit * frame length.
	localparam int BAR_W = LIMIT_W + LEN_W;

	// Per-channel sum of magnitudes, saturating.
	localparam int SUM_W = 40;
	localparam int MAG_W = 17;

	localparam int SAMPLE_W = 16;
	localparam int OUT_CH_W = 3;
	localparam int OUT_POS_W = 32;

	typedef enum logic [1:0] {
		CFG_RATE_HZ,
		CFG_FRAME_MILLIS,
		CFG_ENERGY_LIMIT,
		CFG_CHANNEL_COUNT
	} cfg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       final_req;
	} sample_t;

	typedef struct packed {
		logic [OUT_CH_W-1:0]  channel;
		logic [OUT_POS_W-1:0] seg_start;
		logic [OUT_POS_W-1:0] seg_end;
		logic                 last;
	} seg_t;

	// Settled configuration as the datapath sees it.
	typedef struct packed {
		logic               busy;
		logic [COUNT_W-1:0] channel_count;
		logic [LEN_W-1:0]   frame_len;
		logic [BAR_W-1:0]   bar;
	} cfg_view_t;

	// Stream events reported to the configuration unit.
	typedef struct packed {
		logic open;
		logic start;
		logic close;
	} stream_evt_t;

endpackage

@@ rtl/core/etvad_cfg.sv @@
// Configuration registers, frame length and threshold computation.
module etvad_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  etvad_pkg::cfg_index_t              cfg_index,
	input  logic [etvad_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  etvad_pkg::stream_evt_t             evt,
	output etvad_pkg::cfg_view_t               view
);

	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	logic [etvad_pkg::RATE_W-1:0]   rate_q;
	logic [etvad_pkg::MILLIS_W-1:0] millis_q;
	logic [etvad_pkg::LIMIT_W-1:0]  limit_q;
	logic [etvad_pkg::COUNT_W-1:0]  count_q;
	logic [1:0]                     busy_q;

	logic [etvad_pkg::PROD_W-1:0]   prod_q;
	logic [etvad_pkg::LEN_W-1:0]    len_cfg_q;
	logic [etvad_pkg::LEN_W-1:0]    frame_len_q;
	logic [etvad_pkg::BAR_W-1:0]    bar_q;

	logic [etvad_pkg::PROD_W+etvad_pkg::DIV_MULT_W-1:0] quot_full;
	logic [etvad_pkg::LEN_W-1:0]    len_eff;
	logic                           wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= etvad_pkg::RATE_RESET;
			millis_q <= etvad_pkg::MILLIS_RESET;
			limit_q  <= etvad_pkg::LIMIT_RESET;
			count_q  <= etvad_pkg::COUNT_RESET;
		end else if (wr) begin
			case (cfg_index)
				etvad_pkg::CFG_RATE_HZ: begin
					rate_q <= cfg_data[etvad_pkg::RATE_W-1:0];
				end
				etvad_pkg::CFG_FRAME_MILLIS: begin
					millis_q <= cfg_data[etvad_pkg::MILLIS_W-1:0];
				end
				etvad_pkg::CFG_ENERGY_LIMIT: begin
					limit_q <= cfg_data[etvad_pkg::LIMIT_W-1:0];
				end
				etvad_pkg::CFG_CHANNEL_COUNT: begin
					count_q <= cfg_data[etvad_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Busy holds after a write while prod_q, len_cfg_q and bar_q settle; after a
	// stream closes it holds while bar_q is rebuilt from the configured length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= SETTLE_CYCLES;
		end else if (wr) begin
			busy_q <= SETTLE_CYCLES;
		end else if (evt.close && busy_q == 2'd0) begin
			busy_q <= 2'd1;
		end else if (busy_q != 2'd0) begin
			busy_q <= busy_q - 2'd1;
		end
	end

	assign quot_full = (etvad_pkg::PROD_W+etvad_pkg::DIV_MULT_W)'(prod_q)
		* (etvad_pkg::PROD_W+etvad_pkg::DIV_MULT_W)'(etvad_pkg::DIV_MULT);

	// A stream keeps the frame length that was configured when it opened.
	assign len_eff = evt.open ? frame_len_q : len_cfg_q;

	always_ff @(posedge clk) begin
		prod_q    <= etvad_pkg::PROD_W'(rate_q) * etvad_pkg::PROD_W'(millis_q);
		len_cfg_q <= quot_full[etvad_pkg::DIV_SHIFT +: etvad_pkg::LEN_W];
		bar_q     <= etvad_pkg::BAR_W'(limit_q) * etvad_pkg::BAR_W'(len_eff);
		if (evt.start) begin
			frame_len_q <= len_cfg_q;
		end
	end

	always_comb begin
		view.busy          = (busy_q != 2'd0);
		view.channel_count = count_q;
		view.frame_len     = len_eff;
		view.bar           = bar_q;
	end

endmodule

@@ rtl/core/etvad_seg_buf.sv @@
// Result buffer that hands out the segments closed by one sample, one per transfer.
module etvad_seg_buf #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [MAX_CHANNELS-1:0]           close_mask,
	input  logic [MAX_CHANNELS-1:0]           flush_mask,
	input  logic [etvad_pkg::OUT_POS_W-1:0]   start [MAX_CHANNELS],
	input  logic [etvad_pkg::OUT_POS_W-1:0]   end_close,
	input  logic [etvad_pkg::OUT_POS_W-1:0]   end_flush,
	output logic                              free,
	output logic                              seg_valid,
	input  logic                              seg_stall,
	output etvad_pkg::seg_t                   seg_item
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [MAX_CHANNELS-1:0]         close_q;
	logic [MAX_CHANNELS-1:0]         flush_q;
	logic [etvad_pkg::OUT_POS_W-1:0] start_q [MAX_CHANNELS];
	logic [etvad_pkg::OUT_POS_W-1:0] end_close_q;
	logic [etvad_pkg::OUT_POS_W-1:0] end_flush_q;

	logic                    pick_close;
	logic [MAX_CHANNELS-1:0] pend;
	logic [MAX_CHANNELS-1:0] sel_mask;
	logic [MAX_CHANNELS-1:0] rest_close;
	logic [MAX_CHANNELS-1:0] rest_flush;
	logic [CH_W-1:0]         idx;
	logic                    take;
	logic                    is_last;

	// Segments closed at a frame boundary go out before those flushed at the
	// end of the stream, each group in channel order.
	always_comb begin
		pick_close = |close_q;
		pend = pick_close ? close_q : flush_q;
		idx = '0;
		for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
			if (pend[c]) begin
				idx = CH_W'(c);
			end
		end
		sel_mask   = MAX_CHANNELS'(1) << idx;
		rest_close = pick_close ? (close_q & ~sel_mask) : close_q;
		rest_flush = pick_close ? flush_q : (flush_q & ~sel_mask);
		is_last    = (rest_close == '0) && (rest_flush == '0);
	end

	assign seg_valid = (|close_q) || (|flush_q);
	assign take      = seg_valid && !seg_stall;
	assign free      = !seg_valid || (take && is_last);

	always_comb begin
		seg_item.channel   = etvad_pkg::OUT_CH_W'(idx);
		seg_item.seg_start = start_q[idx];
		seg_item.seg_end   = pick_close ? end_close_q : end_flush_q;
		seg_item.last      = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= '0;
			flush_q <= '0;
		end else if (load) begin
			close_q <= close_mask;
			flush_q <= flush_mask;
		end else if (take) begin
			close_q <= rest_close;
			flush_q <= rest_flush;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_q     <= start;
			end_close_q <= end_close;
			end_flush_q <= end_flush;
		end
	end

endmodule

@@ rtl/core/energy_threshold_vad_core.sv @@
// Energy-threshold voice activity detector: top level with the per-channel frame datapath.
//
// Takes interleaved signed 16-bit samples, one per transfer, and sums each
// channel's magnitudes over frames of rate_hz * frame_millis / 1000 samples.
// A frame whose sum exceeds energy_limit times the frame length is voiced;
// the end of a voiced run yields one segment (channel, start, end), and a
// sample marked final_req flushes every open segment. A sample is taken every
// cycle unless the input is stalled: it is registered, then judged and folded
// into the channel state, and its segments are loaded into the result buffer
// in the same cycle as that state update. The output channel moves one segment
// per transfer, and a sample that closes segments is held while the buffer
// still drains those of an earlier sample. After a configuration write the
// input pauses while the frame length multiply, the reciprocal divide by 1000
// and the threshold multiply settle, and after a final sample it pauses to
// rebuild the threshold. Register writes made while a stream is open keep
// that stream's frame length.
module energy_threshold_vad_core #(
	parameter int MAX_CHANNELS = 8,
	parameter int POS_BITS     = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  etvad_pkg::sample_t                sample_item,
	output logic                              seg_valid,
	input  logic                              seg_stall,
	output etvad_pkg::seg_t                   seg_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  etvad_pkg::cfg_index_t             cfg_index,
	input  logic [etvad_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > etvad_pkg::COUNT_W)
		? $clog2(MAX_CHANNELS + 1) : etvad_pkg::COUNT_W;
	localparam int SUM_W = etvad_pkg::SUM_W;
	localparam int LEN_W = etvad_pkg::LEN_W;

	// Input stage.
	logic               valid_s1;
	etvad_pkg::sample_t item_s1;

	// Stream state.
	logic [SUM_W-1:0]    frame_sum_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] voiced_q;
	logic [POS_BITS-1:0] open_start_q [MAX_CHANNELS];
	logic [CH_W-1:0]     chan_pos_q;
	logic [LEN_W-1:0]    in_frame_q;
	logic [POS_BITS-1:0] origin_q;
	logic [POS_BITS-1:0] total_q;
	logic                stream_open_q;

	etvad_pkg::cfg_view_t   view;
	etvad_pkg::stream_evt_t evt;

	logic [CNT_W-1:0]        count_x;
	logic [CNT_W-1:0]        chans;
	logic                    mono;
	logic [CH_W-1:0]         ch;
	logic [15:0]             raw;
	logic [etvad_pkg::MAG_W-1:0] mag;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_new;
	logic                    group_end;
	logic [LEN_W-1:0]        in_frame_inc;
	logic                    frame_done;
	logic [POS_BITS-1:0]     origin_next;
	logic [POS_BITS-1:0]     total_inc;
	logic [POS_BITS-1:0]     end_flush;

	logic [MAX_CHANNELS-1:0] active;
	logic [MAX_CHANNELS-1:0] loud;
	logic [MAX_CHANNELS-1:0] open_mask;
	logic [MAX_CHANNELS-1:0] close_mask;
	logic [MAX_CHANNELS-1:0] flush_mask;
	logic [MAX_CHANNELS-1:0] voiced_mid;
	logic [SUM_W-1:0]        sum_upd  [MAX_CHANNELS];
	logic [SUM_W-1:0]        sum_next [MAX_CHANNELS];
	logic [POS_BITS-1:0]     start_mid [MAX_CHANNELS];
	logic [etvad_pkg::OUT_POS_W-1:0] buf_start [MAX_CHANNELS];

	logic emit_any;
	logic buf_free;
	logic adv;

	etvad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt       (evt),
		.view      (view)
	);

	// The registered sample moves on once the threshold is settled and the
	// result buffer can take whatever segments it closes.
	assign adv = valid_s1 && !view.busy && (!emit_any || buf_free);
	assign sample_stall = view.busy || (valid_s1 && !adv);

	always_comb begin
		evt.open  = stream_open_q;
		evt.start = adv && !stream_open_q;
		evt.close = adv && item_s1.final_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample_item;
		end
	end

	// Channel group: zero acts as one, anything above the build limit is clipped.
	always_comb begin
		count_x = CNT_W'(view.channel_count);
		if (count_x == '0) begin
			chans = CNT_W'(1);
		end else if (count_x > CNT_W'(MAX_CHANNELS)) begin
			chans = CNT_W'(MAX_CHANNELS);
		end else begin
			chans = count_x;
		end
		mono = (view.channel_count <= etvad_pkg::COUNT_W'(1));
		ch = (CNT_W'(chan_pos_q) >= chans) ? '0 : chan_pos_q;
	end

	always_comb begin
		raw = item_s1.sample;
		mag = raw[15] ? (etvad_pkg::MAG_W'(17'h10000) - etvad_pkg::MAG_W'(raw))
			: etvad_pkg::MAG_W'(raw);
		sum_add = (SUM_W+1)'(frame_sum_q[ch]) + (SUM_W+1)'(mag);
		sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

		group_end    = (CNT_W'(ch) + CNT_W'(1)) >= chans;
		in_frame_inc = in_frame_q + LEN_W'(1);
		frame_done   = group_end && (view.frame_len != '0)
			&& (in_frame_inc == view.frame_len);
		origin_next  = origin_q + POS_BITS'(view.frame_len);
		total_inc    = total_q + POS_BITS'(1);
	end

	// Every channel of the group is judged at once when a frame completes.
	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			active[c]     = CNT_W'(c) < chans;
			sum_upd[c]    = (CH_W'(c) == ch) ? sum_new : frame_sum_q[c];
			loud[c]       = sum_upd[c] > SUM_W'(view.bar);
			open_mask[c]  = frame_done && active[c] && loud[c] && !voiced_q[c];
			close_mask[c] = frame_done && active[c] && !loud[c] && voiced_q[c];
			voiced_mid[c] = voiced_q[c] ^ (open_mask[c] || close_mask[c]);
			start_mid[c]  = open_mask[c] ? origin_q : open_start_q[c];
			sum_next[c]   = (frame_done && active[c]) ? '0 : sum_upd[c];
			flush_mask[c] = item_s1.final_req && active[c] && voiced_mid[c];
			buf_start[c]  = etvad_pkg::OUT_POS_W'(start_mid[c]);
		end
		emit_any  = (|close_mask) || (|flush_mask);
		end_flush = mono ? total_inc : (frame_done ? origin_next : origin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				frame_sum_q[c]  <= '0;
				open_start_q[c] <= '0;
			end
			voiced_q      <= '0;
			chan_pos_q    <= '0;
			in_frame_q    <= '0;
			origin_q      <= '0;
			total_q       <= '0;
			stream_open_q <= 1'b0;
		end else if (adv) begin
			if (item_s1.final_req) begin
				for (int c = 0; c < MAX_CHANNELS; c++) begin
					frame_sum_q[c]  <= '0;
					open_start_q[c] <= '0;
				end
				voiced_q      <= '0;
				chan_pos_q    <= '0;
				in_frame_q    <= '0;
				origin_q      <= '0;
				total_q       <= '0;
				stream_open_q <= 1'b0;
			end else begin
				for (int c = 0; c < MAX_CHANNELS; c++) begin
					frame_sum_q[c]  <= sum_next[c];
					open_start_q[c] <= start_mid[c];
				end
				voiced_q   <= voiced_mid;
				chan_pos_q <= group_end ? '0 : (ch + CH_W'(1));
				if (frame_done) begin
					in_frame_q <= '0;
				end else if (group_end) begin
					in_frame_q <= in_frame_inc;
				end
				origin_q      <= frame_done ? origin_next : origin_q;
				total_q       <= total_inc;
				stream_open_q <= 1'b1;
			end
		end
	end

	etvad_seg_buf #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_seg_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && emit_any),
		.close_mask (close_mask),
		.flush_mask (flush_mask),
		.start      (buf_start),
		.end_close  (etvad_pkg::OUT_POS_W'(origin_q)),
		.end_flush  (etvad_pkg::OUT_POS_W'(end_flush)),
		.free       (buf_free),
		.seg_valid  (seg_valid),
		.seg_stall  (seg_stall),
		.seg_item   (seg_item)
	);

endmodule
